// File: design/utf8_pkg.sv
`timescale 1ns / 1ps
// Shared types, status codes and helper functions for the UTF-8 stream decoder.
// Used by the decode step, the pipeline stages and the top level; no dependencies.
package utf8_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_OVERLONG  = 3'd3,
    ST_SURROGATE = 3'd4,
    ST_RANGE     = 3'd5,
    ST_TRUNC     = 3'd6
  } status_e;

  localparam logic [20:0] MAX_SCALAR     = 21'h10FFFF;
  localparam logic [20:0] SURROGATE_LO   = 21'h00D800;
  localparam logic [20:0] SURROGATE_HI   = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
  localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;
  localparam logic [20:0] MIN_FOUR_BYTE  = 21'h010000;

  // One byte of the input string.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    status_e     status;
    logic        string_end;
    logic        string_ok;
  } out_item_t;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [1:0]  bytes_left;
    logic [2:0]  sequence_size;
    logic [20:0] partial_value;
    logic        error_seen;
  } dec_state_t;

  // Handshake status between the pipeline stages.
  typedef struct packed {
    logic take;   // the input register hands its byte to the decode step
    logic load;   // the result register captures a new result
  } stage_ctrl_t;

  // Sequence length announced by a lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (!b[7]) begin
      n = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Smallest scalar value that a sequence of the given length may carry.
  function automatic logic [20:0] min_value(logic [2:0] size);
    logic [20:0] v;
    case (size)
      3'd2: v = MIN_TWO_BYTE;
      3'd3: v = MIN_THREE_BYTE;
      3'd4: v = MIN_FOUR_BYTE;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/utf8_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries the input bytes of the string.
// Stand-alone; no package dependency.
interface utf8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: design/utf8_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries the decoded results.
// Stand-alone; no package dependency.
interface utf8_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  byte_count;
  logic [2:0]  status;
  logic        string_end;
  logic        string_ok;

  modport source (output valid, output code_point, output byte_count, output status,
                  output string_end, output string_ok, input ready);
  modport sink   (input valid, input code_point, input byte_count, input status,
                  input string_end, input string_ok, output ready);
endinterface

// File: design/utf8_in_stage.sv
`timescale 1ns / 1ps
// Input register of the decoder: holds one accepted byte until the decode step takes it.
// Depends on utf8_pkg.
module utf8_in_stage
  import utf8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  input  stage_ctrl_t ctrl_i,
  output logic        valid_o,
  output in_item_t    item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  // A new byte may enter when the register is empty or is being emptied now.
  assign in_ready_o = !valid_q || ctrl_i.take;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (ctrl_i.take) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: design/utf8_step.sv
`timescale 1ns / 1ps
// Decode step: from the current state and one byte, the next state and an optional result.
// Depends on utf8_pkg.
module utf8_step
  import utf8_pkg::*;
(
  input  dec_state_t state_i,
  input  in_item_t   item_i,
  output dec_state_t state_o,
  output logic       emit_o,
  output out_item_t  result_o
);

  always_comb begin
    logic [2:0]  n;
    logic [20:0] pv;
    logic [1:0]  bl_new;
    logic        do_finish;
    logic [20:0] fin_cp;
    logic [2:0]  fin_sz;
    logic        do_fail;
    status_e     fail_st;
    logic        last;

    last      = item_i.last_byte;
    n         = lead_len(item_i.in_byte);
    pv        = {state_i.partial_value[14:0], item_i.in_byte[5:0]};
    bl_new    = state_i.bytes_left - 2'd1;
    do_finish = 1'b0;
    fin_cp    = '0;
    fin_sz    = '0;
    do_fail   = 1'b0;
    fail_st   = ST_OK;
    state_o   = state_i;
    emit_o    = 1'b0;
    result_o  = '0;
    result_o.status = ST_OK;

    if (state_i.error_seen) begin
      // Skip bytes after an error; the last byte closes the string as invalid.
      if (last) begin
        emit_o              = 1'b1;
        result_o.string_end = 1'b1;
        state_o             = '0;
      end
    end else if (state_i.bytes_left == 2'd0) begin
      // Expecting a lead byte.
      if (n == 3'd0) begin
        do_fail = 1'b1;
        fail_st = ST_BAD_LEAD;
      end else if (n == 3'd1) begin
        do_finish = 1'b1;
        fin_cp    = {13'd0, item_i.in_byte};
        fin_sz    = 3'd1;
      end else if (last) begin
        do_fail = 1'b1;
        fail_st = ST_TRUNC;
      end else begin
        case (n)
          3'd2:    state_o.partial_value = {16'd0, item_i.in_byte[4:0]};
          3'd3:    state_o.partial_value = {17'd0, item_i.in_byte[3:0]};
          default: state_o.partial_value = {18'd0, item_i.in_byte[2:0]};
        endcase
        state_o.sequence_size = n;
        state_o.bytes_left    = 2'(n - 3'd1);
      end
    end else begin
      // Expecting a continuation byte.
      if (item_i.in_byte[7:6] != 2'b10) begin
        do_fail = 1'b1;
        fail_st = ST_BAD_CONT;
      end else if (bl_new == 2'd0) begin
        do_finish = 1'b1;
        fin_cp    = pv;
        fin_sz    = state_i.sequence_size;
      end else if (last) begin
        do_fail = 1'b1;
        fail_st = ST_TRUNC;
      end else begin
        state_o.partial_value = pv;
        state_o.bytes_left    = bl_new;
      end
    end

    // Range checks on a completed sequence: overlong, surrogate, above range.
    if (do_finish) begin
      if (fin_cp < min_value(fin_sz)) begin
        do_fail = 1'b1;
        fail_st = ST_OVERLONG;
      end else if (fin_cp >= SURROGATE_LO && fin_cp <= SURROGATE_HI) begin
        do_fail = 1'b1;
        fail_st = ST_SURROGATE;
      end else if (fin_cp > MAX_SCALAR) begin
        do_fail = 1'b1;
        fail_st = ST_RANGE;
      end else begin
        emit_o              = 1'b1;
        result_o.code_point = fin_cp;
        result_o.byte_count = fin_sz;
        result_o.string_end = last;
        result_o.string_ok  = last;
        state_o             = '0;
      end
    end

    // Error report; within a string the error is remembered until its end.
    if (do_fail) begin
      emit_o               = 1'b1;
      result_o             = '0;
      result_o.status      = fail_st;
      result_o.string_end  = last;
      state_o              = '0;
      state_o.error_seen   = !last;
    end
  end

endmodule

// File: design/utf8_out_stage.sv
`timescale 1ns / 1ps
// Result register of the decoder: holds one result request until the sink takes it.
// Depends on utf8_pkg.
module utf8_out_stage
  import utf8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stage_ctrl_t ctrl_i,
  input  out_item_t   result_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   result_o
);

  logic      valid_q, valid_d;
  out_item_t result_q;

  // The register can take a result when empty or when its content leaves now.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// File: design/utf8_stream_decoder_validator.sv
`timescale 1ns / 1ps
// Top level of the streaming UTF-8 decoder and validator.
// Depends on utf8_pkg, utf8_in_if, utf8_out_if, utf8_in_stage, utf8_step, utf8_out_stage.

// The block takes one byte of a UTF-8 string per request on in_i, with last_byte set on the
// final byte, and returns on out_o one result for each completed code point, each error found,
// and the string end. It accepts one byte every clock cycle as long as out_o is not stalled;
// a byte passes an input register, combinational decode logic that also updates the sequence
// state, and a result register, which offers the result on out_o until the sink takes it.
// The sequence state is updated in the same cycle as the decode, which is what lets the next
// byte follow straight away. Status codes: 0 ok, 1 bad lead, 2 bad continuation, 3 overlong,
// 4 surrogate, 5 above U+10FFFF, 6 truncated. After an error, bytes are dropped until the last
// byte, which closes the string with string_ok low. A string may not be empty.
module utf8_stream_decoder_validator
  import utf8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  utf8_in_if.sink    in_i,
  utf8_out_if.source out_o
);

  in_item_t    in_item;
  in_item_t    cur_item;
  logic        cur_valid;
  logic        out_free;
  stage_ctrl_t ctrl;
  dec_state_t  state_q, state_d;
  logic        emit;
  out_item_t   step_result;
  out_item_t   out_item;

  assign in_item.in_byte   = in_i.in_byte;
  assign in_item.last_byte = in_i.last_byte;

  // Input register.
  utf8_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_item_i  (in_item),
    .ctrl_i     (ctrl),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  // Decode logic.
  utf8_step u_step (
    .state_i  (state_q),
    .item_i   (cur_item),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (step_result)
  );

  // A byte is decoded only when its possible result has somewhere to go.
  assign ctrl.take = cur_valid && out_free;
  assign ctrl.load = ctrl.take && emit;

  // Sequence state advances once per decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctrl.take) begin
      state_q <= state_d;
    end
  end

  // Result register.
  utf8_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .result_i    (step_result),
    .free_o      (out_free),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_item)
  );

  assign out_o.code_point = out_item.code_point;
  assign out_o.byte_count = out_item.byte_count;
  assign out_o.status     = out_item.status;
  assign out_o.string_end = out_item.string_end;
  assign out_o.string_ok  = out_item.string_ok;

`ifndef SYNTHESIS
  // The string end always returns the decoder to its idle state.
  a_end_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.take && cur_item.last_byte |=> state_q == '0)
    else $error("state not cleared after the last byte");

  // While an error is pending no sequence is open.
  a_error_no_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.error_seen |-> state_q.bytes_left == 2'd0 && state_q.partial_value == '0)
    else $error("open sequence while an error is pending");

  // A decoded code point is only ever reported with an ok status.
  a_count_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_count != 3'd0 |-> out_o.status == ST_OK)
    else $error("code point reported with an error status");

  // A valid string verdict only comes with the string end and no error.
  a_ok_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.string_ok |-> out_o.string_end && out_o.status == ST_OK)
    else $error("string_ok without a clean string end");
`endif

endmodule
